### sv/brsm_pkg.sv
// ----------------------------------------------------------------------------
// brsm_pkg - shared types and codes for the bit stream run statistics monitor
// Holds command, group and scalar index codes, the decoded operation passed
// from the front end to the back end, and queue sizing constants.
// ----------------------------------------------------------------------------
package brsm_pkg;

  // Default histogram depth (run lengths 1 .. depth-1 are recorded)
  localparam int HIST_DEPTH_DEF = 32;

  // Queue sizing
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Field widths
  localparam int IN_DATA_W = 8;
  localparam int STAT_W    = 64;
  localparam int IDX_W     = 5;

  typedef logic [STAT_W-1:0] stat_t;

  // Command codes (carried in tuser)
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Read groups
  localparam logic [1:0] GRP_SCALAR    = 2'd0;
  localparam logic [1:0] GRP_ZERO_HIST = 2'd1;
  localparam logic [1:0] GRP_ONE_HIST  = 2'd2;

  // Scalar read indexes
  localparam logic [IDX_W-1:0] RD_BITS     = 5'd0;
  localparam logic [IDX_W-1:0] RD_ONES     = 5'd1;
  localparam logic [IDX_W-1:0] RD_ZERO_MAX = 5'd2;
  localparam logic [IDX_W-1:0] RD_ONE_MAX  = 5'd3;
  localparam logic [IDX_W-1:0] RD_ZERO_NOW = 5'd4;
  localparam logic [IDX_W-1:0] RD_ONE_NOW  = 5'd5;
  localparam logic [IDX_W-1:0] RD_PAIR_00  = 5'd6;
  localparam logic [IDX_W-1:0] RD_PAIR_01  = 5'd7;
  localparam logic [IDX_W-1:0] RD_PAIR_10  = 5'd8;
  localparam logic [IDX_W-1:0] RD_PAIR_11  = 5'd9;

  // Histogram polarity (top address bit)
  localparam logic POL_ZERO = 1'b0;
  localparam logic POL_ONE  = 1'b1;

  // Decoded operation kinds
  typedef enum logic [1:0] {
    OP_FEED      = 2'd0,
    OP_RD_SCALAR = 2'd1,
    OP_RD_HIST   = 2'd2,
    OP_RD_NONE   = 2'd3
  } op_kind_t;

  // Operation as queued between front and back end
  typedef struct packed {
    op_kind_t         kind;
    logic             stream_bit;
    logic             pol;
    logic [IDX_W-1:0] index;
  } op_t;

  // Stage control travelling down the back-end pipeline
  typedef struct packed {
    logic emit;  // transaction produces a result
    logic mem;   // transaction touches the histogram memory
  } stage_ctrl_t;

endpackage

### sv/brsm_fifo.sv
// ----------------------------------------------------------------------------
// brsm_fifo - small register-based FIFO
// First-word-fall-through queue used for the command queue and the result
// queue. Push is ignored when full, pop is ignored when empty.
// ----------------------------------------------------------------------------
module brsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push    = wr_en && !full;
  assign pop     = rd_en && !empty;
  assign rd_data = store_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### sv/brsm_front.sv
// ----------------------------------------------------------------------------
// brsm_front - input handshake and command classification
// Unpacks the input transaction and decides what the back end must do with
// it: feed a bit, read a scalar, read a histogram entry, or return zero.
// ----------------------------------------------------------------------------
module brsm_front #(
  parameter int HIST_DEPTH = brsm_pkg::HIST_DEPTH_DEF
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [brsm_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output brsm_pkg::op_t                  q_op
);

  logic                         stream_bit;
  logic [1:0]                   read_group;
  logic [brsm_pkg::IDX_W-1:0]   read_index;
  brsm_pkg::op_kind_t           kind;

  assign stream_bit = in_tdata[0];
  assign read_group = in_tdata[2:1];
  assign read_index = in_tdata[7:3];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classify the transaction
  always_comb begin
    kind = brsm_pkg::OP_RD_NONE;
    if (in_tuser == brsm_pkg::CMD_FEED) begin
      kind = brsm_pkg::OP_FEED;
    end else begin
      unique case (read_group) inside
        brsm_pkg::GRP_SCALAR: begin
          kind = (read_index <= brsm_pkg::RD_PAIR_11) ? brsm_pkg::OP_RD_SCALAR
                                                      : brsm_pkg::OP_RD_NONE;
        end
        brsm_pkg::GRP_ZERO_HIST, brsm_pkg::GRP_ONE_HIST: begin
          kind = (int'(read_index) < HIST_DEPTH) ? brsm_pkg::OP_RD_HIST
                                                 : brsm_pkg::OP_RD_NONE;
        end
        default: begin
          kind = brsm_pkg::OP_RD_NONE;
        end
      endcase
    end
  end

  assign q_op.kind       = kind;
  assign q_op.stream_bit = stream_bit;
  assign q_op.pol        = (read_group == brsm_pkg::GRP_ONE_HIST) ? brsm_pkg::POL_ONE
                                                                  : brsm_pkg::POL_ZERO;
  assign q_op.index      = read_index;

endmodule

### sv/brsm_core.sv
// ----------------------------------------------------------------------------
// brsm_core - scalar counters and run tracking
// Applies each fed bit to the bit, ones, run and pair counters, raises a
// histogram increment when a run closes, and answers scalar reads.
// ----------------------------------------------------------------------------
module brsm_core #(
  parameter int HIST_DEPTH = brsm_pkg::HIST_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        issue,
  input  brsm_pkg::op_t               op,
  output brsm_pkg::stage_ctrl_t       p1_ctrl,
  output logic [$clog2(HIST_DEPTH):0] p1_addr,
  output brsm_pkg::stat_t             p1_value
);

  localparam int HIDX_W = $clog2(HIST_DEPTH);
  localparam int ADDR_W = HIDX_W + 1;

  brsm_pkg::stat_t bit_cnt_r,  bit_cnt_nxt;
  brsm_pkg::stat_t ones_cnt_r, ones_cnt_nxt;
  brsm_pkg::stat_t zero_now_r, zero_now_nxt;
  brsm_pkg::stat_t one_now_r,  one_now_nxt;
  brsm_pkg::stat_t zero_max_r, zero_max_nxt;
  brsm_pkg::stat_t one_max_r,  one_max_nxt;
  brsm_pkg::stat_t pair_r   [4];
  brsm_pkg::stat_t pair_nxt [4];
  logic            prev_r, prev_nxt;

  brsm_pkg::stage_ctrl_t p1_ctrl_r, p1_ctrl_nxt;
  logic [ADDR_W-1:0]     p1_addr_r, p1_addr_nxt;
  brsm_pkg::stat_t       p1_value_r, p1_value_nxt;

  brsm_pkg::stat_t zero_inc, one_inc, scalar_val;
  logic [1:0]      pair_sel;

  assign zero_inc = zero_now_r + brsm_pkg::STAT_W'(1);
  assign one_inc  = one_now_r + brsm_pkg::STAT_W'(1);
  assign pair_sel = {prev_r, op.stream_bit};

  // Scalar read mux
  always_comb begin
    unique case (op.index)
      brsm_pkg::RD_BITS:     scalar_val = bit_cnt_r;
      brsm_pkg::RD_ONES:     scalar_val = ones_cnt_r;
      brsm_pkg::RD_ZERO_MAX: scalar_val = zero_max_r;
      brsm_pkg::RD_ONE_MAX:  scalar_val = one_max_r;
      brsm_pkg::RD_ZERO_NOW: scalar_val = zero_now_r;
      brsm_pkg::RD_ONE_NOW:  scalar_val = one_now_r;
      brsm_pkg::RD_PAIR_00:  scalar_val = pair_r[0];
      brsm_pkg::RD_PAIR_01:  scalar_val = pair_r[1];
      brsm_pkg::RD_PAIR_10:  scalar_val = pair_r[2];
      brsm_pkg::RD_PAIR_11:  scalar_val = pair_r[3];
      default:               scalar_val = '0;
    endcase
  end

  // Counter update and stage-1 issue
  always_comb begin
    bit_cnt_nxt  = bit_cnt_r;
    ones_cnt_nxt = ones_cnt_r;
    zero_now_nxt = zero_now_r;
    one_now_nxt  = one_now_r;
    zero_max_nxt = zero_max_r;
    one_max_nxt  = one_max_r;
    prev_nxt     = prev_r;
    for (int k = 0; k < 4; k++) begin
      pair_nxt[k] = pair_r[k];
    end
    p1_ctrl_nxt  = '0;
    p1_addr_nxt  = p1_addr_r;
    p1_value_nxt = p1_value_r;

    if (issue) begin
      unique case (op.kind)
        brsm_pkg::OP_FEED: begin
          bit_cnt_nxt = bit_cnt_r + brsm_pkg::STAT_W'(1);
          if (op.stream_bit) begin
            ones_cnt_nxt = ones_cnt_r + brsm_pkg::STAT_W'(1);
            one_now_nxt  = one_inc;
            if (one_inc > one_max_r) begin
              one_max_nxt = one_inc;
            end
            // a one closes the zero run
            if (zero_now_r != '0) begin
              zero_now_nxt = '0;
              if (zero_now_r < brsm_pkg::STAT_W'(HIST_DEPTH)) begin
                p1_ctrl_nxt.mem = 1'b1;
                p1_addr_nxt = {brsm_pkg::POL_ZERO,
                               zero_now_r[HIDX_W-1:0] - HIDX_W'(1)};
              end
            end
          end else begin
            zero_now_nxt = zero_inc;
            if (zero_inc > zero_max_r) begin
              zero_max_nxt = zero_inc;
            end
            // a zero closes the one run
            if (one_now_r != '0) begin
              one_now_nxt = '0;
              if (one_now_r < brsm_pkg::STAT_W'(HIST_DEPTH)) begin
                p1_ctrl_nxt.mem = 1'b1;
                p1_addr_nxt = {brsm_pkg::POL_ONE,
                               one_now_r[HIDX_W-1:0] - HIDX_W'(1)};
              end
            end
          end
          for (int k = 0; k < 4; k++) begin
            if (pair_sel == 2'(k)) begin
              pair_nxt[k] = pair_r[k] + brsm_pkg::STAT_W'(1);
            end
          end
          prev_nxt = op.stream_bit;
        end
        brsm_pkg::OP_RD_SCALAR: begin
          p1_ctrl_nxt.emit = 1'b1;
          p1_value_nxt     = scalar_val;
        end
        brsm_pkg::OP_RD_HIST: begin
          p1_ctrl_nxt.emit = 1'b1;
          p1_ctrl_nxt.mem  = 1'b1;
          p1_addr_nxt      = {op.pol, HIDX_W'(op.index)};
        end
        default: begin
          p1_ctrl_nxt.emit = 1'b1;
          p1_value_nxt     = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r  <= '0;
      ones_cnt_r <= '0;
      zero_now_r <= '0;
      one_now_r  <= '0;
      zero_max_r <= '0;
      one_max_r  <= '0;
      prev_r     <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        pair_r[k] <= '0;
      end
      p1_ctrl_r  <= '0;
    end else begin
      bit_cnt_r  <= bit_cnt_nxt;
      ones_cnt_r <= ones_cnt_nxt;
      zero_now_r <= zero_now_nxt;
      one_now_r  <= one_now_nxt;
      zero_max_r <= zero_max_nxt;
      one_max_r  <= one_max_nxt;
      prev_r     <= prev_nxt;
      for (int k = 0; k < 4; k++) begin
        pair_r[k] <= pair_nxt[k];
      end
      p1_ctrl_r  <= p1_ctrl_nxt;
    end
  end

  // Stage-1 payload
  always_ff @(posedge clk) begin
    p1_addr_r  <= p1_addr_nxt;
    p1_value_r <= p1_value_nxt;
  end

  assign p1_ctrl  = p1_ctrl_r;
  assign p1_addr  = p1_addr_r;
  assign p1_value = p1_value_r;

endmodule

### sv/brsm_hist.sv
// ----------------------------------------------------------------------------
// brsm_hist - run-length histogram memory and result stage
// Both histograms share one memory addressed by {polarity, length-1}. A run
// close reads the entry, then writes back plus one; a back-to-back access to
// the same entry picks up the write data by forwarding. After reset a clearing
// pass zeroes the memory, one entry per cycle over all 2^ADDR_W entries.
// ----------------------------------------------------------------------------
module brsm_hist #(
  parameter int HIST_DEPTH = brsm_pkg::HIST_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  brsm_pkg::stage_ctrl_t       p1_ctrl,
  input  logic [$clog2(HIST_DEPTH):0] p1_addr,
  input  brsm_pkg::stat_t             p1_value,
  output logic                        clearing,
  output logic                        res_valid,
  output brsm_pkg::stat_t             res_value
);

  localparam int ADDR_W  = $clog2(HIST_DEPTH) + 1;
  localparam int ENTRIES = 2 ** ADDR_W;

  brsm_pkg::stat_t       hist_mem [ENTRIES];
  logic                  clr_busy_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  brsm_pkg::stage_ctrl_t p2_ctrl_r;
  logic [ADDR_W-1:0]     p2_addr_r;
  brsm_pkg::stat_t       p2_value_r;
  brsm_pkg::stat_t       rd_data_r;

  brsm_pkg::stat_t wr_data;
  logic            wr_en, fwd;

  // Stage 2 result: entry value plus one for a run close
  assign wr_data = rd_data_r + brsm_pkg::STAT_W'(1);
  assign wr_en   = p2_ctrl_r.mem && !p2_ctrl_r.emit;
  assign fwd     = wr_en && (p2_addr_r == p1_addr);

  // Memory write (clearing pass or increment) and registered read with forwarding
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      hist_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      hist_mem[p2_addr_r] <= wr_data;
    end
    if (p1_ctrl.mem) begin
      if (fwd) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= hist_mem[p1_addr];
      end
    end
  end

  // Clearing pass and stage-2 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      p2_ctrl_r  <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(ENTRIES - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      p2_ctrl_r <= p1_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    p2_addr_r  <= p1_addr;
    p2_value_r <= p1_value;
  end

  assign clearing = clr_busy_r;

  // Result out
  assign res_valid = p2_ctrl_r.emit;
  assign res_value = p2_ctrl_r.mem ? rd_data_r : p2_value_r;

endmodule

### sv/bitstream_run_statistics_monitor.sv
// ----------------------------------------------------------------------------
// bitstream_run_statistics_monitor - online run statistics for a bit stream
//
// Channel  Ports                         Dir  Payload (low bit first)
// in       in_tvalid in_tready in_tdata  in   tdata: stream_bit, read_group[1:0],
//          in_tuser                             read_index[4:0]; tuser: command
// out      out_tvalid out_tready         out  tdata: read_value[63:0]
//          out_tdata
//
// One transaction per cycle sustained, feeds and reads mixed freely, while no read
// waits for a result slot and no clearing pass runs. A read passes the command
// queue, counter stage, histogram read and result queue. At most four reads in
// flight; a read at the queue head waits for a result slot. Reset (rst_n,
// synchronous, active low) clears the counters; the histogram memory is then
// zeroed one entry per cycle, while input only fills the command queue.
// ----------------------------------------------------------------------------
module bitstream_run_statistics_monitor #(
  parameter int HIST_DEPTH = brsm_pkg::HIST_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [brsm_pkg::IN_DATA_W-1:0] in_tdata,   // stream_bit, read_group, read_index
  input  logic                           in_tuser,   // command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [brsm_pkg::STAT_W-1:0]    out_tdata   // read_value
);

  localparam int ADDR_W = $clog2(HIST_DEPTH) + 1;
  localparam int OCNT_W = $clog2(brsm_pkg::OUT_DEPTH + 1);
  localparam int OP_W   = $bits(brsm_pkg::op_t);

  logic                  q_push, q_full, q_empty, issue, rd_issue, out_pop;
  logic                  can_issue, hist_clearing;
  brsm_pkg::op_t         front_op, q_op;
  logic [OP_W-1:0]       q_rdata;
  brsm_pkg::stage_ctrl_t p1_ctrl;
  logic [ADDR_W-1:0]     p1_addr;
  brsm_pkg::stat_t       p1_value, res_value;
  logic                  res_valid, out_full, out_empty;
  logic [OCNT_W-1:0]     outstanding_r, outstanding_nxt;

  // Front end
  brsm_front #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (front_op)
  );

  // Command queue between front and back end
  brsm_fifo #(
    .WIDTH (OP_W),
    .DEPTH (brsm_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (front_op),
    .full    (q_full),
    .rd_en   (issue),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  assign q_op = brsm_pkg::op_t'(q_rdata);

  // Issue: nothing during the clearing pass, reads need a free result slot
  assign can_issue = !q_empty && !hist_clearing;
  assign rd_issue  = can_issue && (q_op.kind != brsm_pkg::OP_FEED) &&
                     (outstanding_r < OCNT_W'(brsm_pkg::OUT_DEPTH));
  assign issue     = rd_issue || (can_issue && (q_op.kind == brsm_pkg::OP_FEED));
  assign out_pop   = out_tvalid && out_tready;

  assign outstanding_nxt = outstanding_r + OCNT_W'(rd_issue) - OCNT_W'(out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  // Back end: counters, then histogram
  brsm_core #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .op       (q_op),
    .p1_ctrl  (p1_ctrl),
    .p1_addr  (p1_addr),
    .p1_value (p1_value)
  );

  brsm_hist #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .p1_ctrl   (p1_ctrl),
    .p1_addr   (p1_addr),
    .p1_value  (p1_value),
    .clearing  (hist_clearing),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  // Result queue
  brsm_fifo #(
    .WIDTH (brsm_pkg::STAT_W),
    .DEPTH (brsm_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res_value),
    .full    (out_full),
    .rd_en   (out_tready),
    .rd_data (out_tdata),
    .empty   (out_empty)
  );

  assign out_tvalid = !out_empty;

  // Credit scheme must keep the result queue from overflowing
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_full)
    else $error("result written into a full result queue");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= OCNT_W'(brsm_pkg::OUT_DEPTH))
    else $error("reads in flight exceed result queue depth");

  a_result_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (outstanding_r != '0))
    else $error("result presented with no read in flight");

endmodule
